FILE: rtl/pksg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the pair kernel submatrix gather block
// no dependencies

package pksg_pkg;

    localparam int MAX_DIM     = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * DIM_W;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 7;
    localparam int ACC_W       = 34;
    localparam int DIV_STEPS   = IDX_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_PAIR   = 1'b1;

    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_DIRECT_DIM = 2'd1;
    localparam logic [1:0] REG_FIRST_GRP  = 2'd2;
    localparam logic [1:0] REG_SECOND_GRP = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] quotient;
        logic [CFG_W-1:0] remainder;
    } div_result_t;

endpackage

FILE: rtl/pksg_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on pksg_pkg

module pksg_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pksg_pkg::IDX_W-1:0] dividend,
    input  logic [pksg_pkg::CFG_W-1:0] divisor,
    output logic                      done,
    output pksg_pkg::div_result_t     result
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pksg_pkg::STEP_W-1:0] count_reg, count_next;
    logic [pksg_pkg::IDX_W-1:0]  work_reg, work_next;
    logic [pksg_pkg::CFG_W-1:0]  rem_reg, rem_next;
    logic [pksg_pkg::CFG_W-1:0]  divisor_reg, divisor_next;
    logic [pksg_pkg::CFG_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, work_reg[pksg_pkg::IDX_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = pksg_pkg::CFG_W'(trial - {1'b0, divisor_reg});
            else
                rem_next = trial[pksg_pkg::CFG_W-1:0];
            work_next  = {work_reg[pksg_pkg::IDX_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == pksg_pkg::STEP_W'(pksg_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done             = done_reg;
    assign result.quotient  = work_reg;
    assign result.remainder = rem_reg;

endmodule

FILE: rtl/pksg_matrix_ram.sv
`timescale 1ns / 1ps
// single-port matrix store with registered read data
// depends on pksg_pkg

module pksg_matrix_ram
(
    input  logic                            clk,
    input  logic                            we,
    input  logic                            re,
    input  logic [pksg_pkg::ADDR_W-1:0]      addr,
    input  logic [pksg_pkg::VALUE_WIDTH-1:0] wdata,
    output logic [pksg_pkg::VALUE_WIDTH-1:0] rdata
);

    logic [pksg_pkg::VALUE_WIDTH-1:0] mem [pksg_pkg::DEPTH];
    logic [pksg_pkg::VALUE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pair_kernel_submatrix_gather_core.sv
`timescale 1ns / 1ps
// top level: config registers, query sequencer, accumulator and output register
// depends on pksg_pkg, pksg_divider, pksg_matrix_ram

// A write transaction stores one matrix entry. A direct-mode query makes one read of
// the single-port store, waits for the registered read data, then loads the output
// register. A pair-kernel query first splits both indices at once in the bit-serial
// dividers, acts on their done flag, makes four back-to-back reads of the single-port
// store, waits for the last registered read data, then loads the output register.
// Indices out of range skip the reads: the flagged result goes straight to the output
// stage in direct mode or with a zero second group size, and follows the divide when
// the pair split lands outside. The block returns to idle as the result is loaded and
// then takes the next transaction, while that result may still wait in the output
// register; a finished query whose result cannot leave holds the input stalled.
// Configuration writes are always ready and must only be made while the block is idle.

module pair_kernel_submatrix_gather_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [pksg_pkg::CFG_W-1:0]       cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [5:0]                      row,
    input  logic [5:0]                      col,
    input  logic signed [31:0]              data,
    input  logic [9:0]                      index_p,
    input  logic [9:0]                      index_q,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [33:0]              entry_value,
    output logic                            out_of_range
);

    pksg_pkg::state_t state_reg, state_next;

    logic                           mode_reg;
    logic [pksg_pkg::CFG_W-1:0]     direct_dim_reg;
    logic [pksg_pkg::CFG_W-1:0]     n1_reg;
    logic [pksg_pkg::CFG_W-1:0]     n2_reg;

    logic [pksg_pkg::DIM_W-1:0]     ip_reg, ip_next;
    logic [pksg_pkg::DIM_W-1:0]     iq_reg, iq_next;
    logic [pksg_pkg::DIM_W-1:0]     jp_reg, jp_next;
    logic [pksg_pkg::DIM_W-1:0]     jq_reg, jq_next;
    logic                           bad_reg, bad_next;
    logic signed [pksg_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]                     rd_cnt_reg, rd_cnt_next;
    logic                           rd_pending_reg, rd_pending_next;
    logic [1:0]                     rd_sel_reg, rd_sel_next;
    logic [1:0]                     rd_last_reg, rd_last_next;

    logic                           out_valid_reg, out_valid_next;
    logic signed [pksg_pkg::ACC_W-1:0] entry_value_reg, entry_value_next;
    logic                           out_of_range_reg, out_of_range_next;

    logic                           accept;
    logic                           is_query;
    logic                           direct_bad;
    logic                           pair_zero_div;
    logic                           pair_bad;
    logic                           issue;
    logic                           read_last;
    logic                           out_free;
    logic                           div_start;
    logic                           div_done_p, div_done_q;
    pksg_pkg::div_result_t          div_p, div_q;
    logic [pksg_pkg::DIM_W+1:0]     jp_full, jq_full;

    logic                           ram_we, ram_re;
    logic [pksg_pkg::ADDR_W-1:0]    ram_addr;
    logic [pksg_pkg::VALUE_WIDTH-1:0] ram_rdata;
    logic signed [pksg_pkg::ACC_W-1:0] rd_ext;

    // config port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= pksg_pkg::MODE_DIRECT;
            direct_dim_reg <= pksg_pkg::CFG_W'(64);
            n1_reg         <= pksg_pkg::CFG_W'(32);
            n2_reg         <= pksg_pkg::CFG_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pksg_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                pksg_pkg::REG_DIRECT_DIM: direct_dim_reg <= cfg_data;
                pksg_pkg::REG_FIRST_GRP:  n1_reg         <= cfg_data;
                pksg_pkg::REG_SECOND_GRP: n2_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = (state_reg != pksg_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_query = (opcode == pksg_pkg::OP_QUERY);
    assign out_free = !out_valid_reg || !out_stall;

    assign direct_bad = (index_p >= {3'b0, direct_dim_reg})
                     || (index_q >= {3'b0, direct_dim_reg})
                     || (index_p >= pksg_pkg::IDX_W'(pksg_pkg::MAX_DIM))
                     || (index_q >= pksg_pkg::IDX_W'(pksg_pkg::MAX_DIM));
    assign pair_zero_div = (n2_reg == '0);

    assign div_start = accept && is_query && (mode_reg == pksg_pkg::MODE_PAIR)
                    && !pair_zero_div;

    pksg_divider u_div_p
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (index_p),
        .divisor  (n2_reg),
        .done     (div_done_p),
        .result   (div_p)
    );

    pksg_divider u_div_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (index_q),
        .divisor  (n2_reg),
        .done     (div_done_q),
        .result   (div_q)
    );

    assign jp_full = {1'b0, div_p.remainder} + {1'b0, n1_reg};
    assign jq_full = {1'b0, div_q.remainder} + {1'b0, n1_reg};

    assign pair_bad = (div_p.quotient >= {3'b0, n1_reg})
                   || (div_q.quotient >= {3'b0, n1_reg})
                   || (div_p.quotient >= pksg_pkg::IDX_W'(pksg_pkg::MAX_DIM))
                   || (div_q.quotient >= pksg_pkg::IDX_W'(pksg_pkg::MAX_DIM))
                   || (jp_full >= (pksg_pkg::DIM_W+2)'(pksg_pkg::MAX_DIM))
                   || (jq_full >= (pksg_pkg::DIM_W+2)'(pksg_pkg::MAX_DIM));

    assign issue     = (state_reg == pksg_pkg::ST_READ) && (rd_cnt_reg <= {1'b0, rd_last_reg});
    assign read_last = rd_pending_reg && (rd_sel_reg == rd_last_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pksg_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    if (mode_reg == pksg_pkg::MODE_PAIR)
                        state_next = pair_zero_div ? pksg_pkg::ST_FINISH : pksg_pkg::ST_DIV;
                    else
                        state_next = direct_bad ? pksg_pkg::ST_FINISH : pksg_pkg::ST_READ;
                end
            end
            pksg_pkg::ST_DIV:
            begin
                if (div_done_p && div_done_q)
                    state_next = pair_bad ? pksg_pkg::ST_FINISH : pksg_pkg::ST_READ;
            end
            pksg_pkg::ST_READ:
            begin
                if (read_last)
                    state_next = pksg_pkg::ST_FINISH;
            end
            pksg_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = pksg_pkg::ST_IDLE;
            end
            default: state_next = pksg_pkg::ST_IDLE;
        endcase
    end

    // read address select: (ip,iq) (jp,jq) (ip,jq) (jp,iq)
    always_comb
    begin
        case (rd_cnt_reg[1:0])
            2'd0:    ram_addr = {ip_reg, iq_reg};
            2'd1:    ram_addr = {jp_reg, jq_reg};
            2'd2:    ram_addr = {ip_reg, jq_reg};
            default: ram_addr = {jp_reg, iq_reg};
        endcase
        if (state_reg == pksg_pkg::ST_IDLE)
            ram_addr = {row, col};
    end

    assign ram_we = accept && !is_query;
    assign ram_re = issue;

    pksg_matrix_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (data[pksg_pkg::VALUE_WIDTH-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_ext = {{(pksg_pkg::ACC_W - pksg_pkg::VALUE_WIDTH){ram_rdata[pksg_pkg::VALUE_WIDTH-1]}},
                     ram_rdata};

    // datapath and outputs
    always_comb
    begin
        ip_next           = ip_reg;
        iq_next           = iq_reg;
        jp_next           = jp_reg;
        jq_next           = jq_reg;
        bad_next          = bad_reg;
        acc_next          = acc_reg;
        rd_cnt_next       = rd_cnt_reg;
        rd_pending_next   = 1'b0;
        rd_sel_next       = rd_sel_reg;
        rd_last_next      = rd_last_reg;
        out_valid_next    = out_valid_reg && out_stall;
        entry_value_next  = entry_value_reg;
        out_of_range_next = out_of_range_reg;

        case (state_reg)
            pksg_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    ip_next      = index_p[pksg_pkg::DIM_W-1:0];
                    iq_next      = index_q[pksg_pkg::DIM_W-1:0];
                    acc_next     = '0;
                    rd_cnt_next  = '0;
                    rd_last_next = (mode_reg == pksg_pkg::MODE_PAIR) ? 2'd3 : 2'd0;
                    if (mode_reg == pksg_pkg::MODE_PAIR)
                        bad_next = pair_zero_div;
                    else
                        bad_next = direct_bad;
                end
            end
            pksg_pkg::ST_DIV:
            begin
                if (div_done_p && div_done_q)
                begin
                    ip_next  = div_p.quotient[pksg_pkg::DIM_W-1:0];
                    iq_next  = div_q.quotient[pksg_pkg::DIM_W-1:0];
                    jp_next  = jp_full[pksg_pkg::DIM_W-1:0];
                    jq_next  = jq_full[pksg_pkg::DIM_W-1:0];
                    bad_next = pair_bad;
                end
            end
            pksg_pkg::ST_READ:
            begin
                if (issue)
                begin
                    rd_pending_next = 1'b1;
                    rd_sel_next     = rd_cnt_reg[1:0];
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                end
                if (rd_pending_reg)
                begin
                    if (rd_sel_reg[1])
                        acc_next = acc_reg - rd_ext;
                    else
                        acc_next = acc_reg + rd_ext;
                end
            end
            pksg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    entry_value_next  = bad_reg ? '0 : acc_reg;
                    out_of_range_next = bad_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pksg_pkg::ST_IDLE;
            rd_pending_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= rd_pending_next;
            rd_cnt_reg     <= rd_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg           <= ip_next;
        iq_reg           <= iq_next;
        jp_reg           <= jp_next;
        jq_reg           <= jq_next;
        bad_reg          <= bad_next;
        acc_reg          <= acc_next;
        rd_sel_reg       <= rd_sel_next;
        rd_last_reg      <= rd_last_next;
        entry_value_reg  <= entry_value_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign out_valid    = out_valid_reg;
    assign entry_value  = entry_value_reg;
    assign out_of_range = out_of_range_reg;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for pair_kernel_submatrix_gather_core (depends on pksg_pkg and the rtl): a directed
// table, then random phases; each result checked against listed values or an in-bench predictor

module testbench;

    import pksg_pkg::*;

    typedef enum logic {STEP_ITEM, STEP_SETTINGS} step_kind_t;

    typedef struct {
        step_kind_t              kind;
        logic                    op;
        logic [5:0]              row;
        logic [5:0]              col;
        logic [31:0]             data;
        logic [9:0]              p;
        logic [9:0]              q;
        bit                      typed;
        logic signed [ACC_W-1:0] value;
        logic                    oor;
        logic                    mode;
        logic [CFG_W-1:0]        dim;
        logic [CFG_W-1:0]        n1;
        logic [CFG_W-1:0]        n2;
    } step_t;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic                    oor;
    } entry_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic [5:0]              row;
    logic [5:0]              col;
    logic signed [31:0]      data;
    logic [9:0]              index_p;
    logic [9:0]              index_q;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [ACC_W-1:0] entry_value;
    logic                    out_of_range;

    logic signed [31:0] matrix_copy [DEPTH];
    bit                 entry_loaded [DEPTH];
    logic               mode_reg;
    int unsigned        dim_reg;
    int unsigned        n1_reg;
    int unsigned        n2_reg;
    entry_t             pending_entries [$];
    step_t              directed [$];
    int                 errors = 0;
    int                 burst_left = 0;
    int                 stall_cycle = 0;
    int                 stall_style = 0;

    pair_kernel_submatrix_gather_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .row          (row),
        .col          (col),
        .data         (data),
        .index_p      (index_p),
        .index_q      (index_q),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .entry_value  (entry_value),
        .out_of_range (out_of_range)
    );

    always #4 clk = ~clk;

    // addresses a query reads, or bad when it is flagged
    function automatic void split_query(input logic [9:0] p, input logic [9:0] q,
                                        output bit bad, output int unsigned addr [4],
                                        output int cnt);
        int unsigned ip;
        int unsigned iq;
        int unsigned jp;
        int unsigned jq;
        bad = 1'b0;
        cnt = 0;
        foreach (addr[k]) addr[k] = 0;
        if (mode_reg == MODE_DIRECT)
        begin
            if (p >= dim_reg || q >= dim_reg || p >= MAX_DIM || q >= MAX_DIM)
                bad = 1'b1;
            else
            begin
                addr[0] = p * MAX_DIM + q;
                cnt = 1;
            end
        end
        else if (n2_reg == 0)
            bad = 1'b1;
        else
        begin
            ip = p / n2_reg;
            jp = p % n2_reg + n1_reg;
            iq = q / n2_reg;
            jq = q % n2_reg + n1_reg;
            if (ip >= n1_reg || iq >= n1_reg || ip >= MAX_DIM || iq >= MAX_DIM ||
                jp >= MAX_DIM || jq >= MAX_DIM)
                bad = 1'b1;
            else
            begin
                addr[0] = ip * MAX_DIM + iq;
                addr[1] = jp * MAX_DIM + jq;
                addr[2] = ip * MAX_DIM + jq;
                addr[3] = jp * MAX_DIM + iq;
                cnt = 4;
            end
        end
    endfunction

    function automatic entry_t kernel_entry(input logic [9:0] p, input logic [9:0] q);
        entry_t                  e;
        bit                      bad;
        int unsigned             addr [4];
        int                      cnt;
        logic signed [ACC_W-1:0] t [4];
        split_query(p, q, bad, addr, cnt);
        foreach (t[k]) t[k] = ACC_W'(matrix_copy[addr[k]]);
        e.oor = bad;
        if (bad)
            e.value = '0;
        else if (cnt == 1)
            e.value = t[0];
        else
            e.value = t[0] + t[1] - t[2] - t[3];
        return e;
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic step_t blank_step();
        step_t s;
        s.kind  = STEP_ITEM;
        s.op    = OP_WRITE;
        s.row   = 6'($urandom());
        s.col   = 6'($urandom());
        s.data  = $urandom();
        s.p     = 10'($urandom());
        s.q     = 10'($urandom());
        s.typed = 1'b0;
        s.value = '0;
        s.oor   = 1'b0;
        s.mode  = MODE_DIRECT;
        s.dim   = '0;
        s.n1    = '0;
        s.n2    = '0;
        return s;
    endfunction

    function automatic step_t put_entry(input logic [5:0] r, input logic [5:0] c,
                                        input logic [31:0] d);
        step_t s;
        s = blank_step();
        s.row  = r;
        s.col  = c;
        s.data = d;
        return s;
    endfunction

    function automatic step_t ask(input logic [9:0] p, input logic [9:0] q);
        step_t s;
        s = blank_step();
        s.op = OP_QUERY;
        s.p  = p;
        s.q  = q;
        return s;
    endfunction

    function automatic step_t ask_known(input logic [9:0] p, input logic [9:0] q,
                                        input logic signed [ACC_W-1:0] v, input logic o);
        step_t s;
        s = ask(p, q);
        s.typed = 1'b1;
        s.value = v;
        s.oor   = o;
        return s;
    endfunction

    function automatic step_t settings(input logic m, input logic [CFG_W-1:0] dim,
                                       input logic [CFG_W-1:0] n1, input logic [CFG_W-1:0] n2);
        step_t s;
        s = blank_step();
        s.kind = STEP_SETTINGS;
        s.mode = m;
        s.dim  = dim;
        s.n1   = n1;
        s.n2   = n2;
        return s;
    endfunction

    // working-set index whose split stays inside the stored matrix
    function automatic logic [9:0] pair_index();
        int unsigned span;
        int unsigned ip_max;
        span = (n2_reg < MAX_DIM - n1_reg) ? n2_reg : MAX_DIM - n1_reg;
        ip_max = (1023 - (span - 1)) / n2_reg;
        if (ip_max > n1_reg - 1)
            ip_max = n1_reg - 1;
        return 10'($urandom_range(0, ip_max) * n2_reg + $urandom_range(0, span - 1));
    endfunction

    function automatic step_t random_step();
        step_t       s;
        int unsigned lim;
        s = blank_step();
        if ($urandom_range(0, 9) < 3)
        begin
            s.data = pick_data();
            return s;
        end
        s.op = OP_QUERY;
        if ($urandom_range(0, 3) == 0)
            return s;
        if (mode_reg == MODE_DIRECT)
        begin
            lim = (dim_reg < MAX_DIM) ? dim_reg : MAX_DIM;
            if (lim > 0)
            begin
                s.p = 10'($urandom_range(0, lim - 1));
                s.q = 10'($urandom_range(0, lim - 1));
            end
        end
        else if (n2_reg > 0 && n1_reg > 0 && n1_reg < MAX_DIM)
        begin
            s.p = pair_index();
            s.q = pair_index();
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic send_item(input logic op, input logic [5:0] r, input logic [5:0] c,
                             input logic [31:0] d, input logic [9:0] p, input logic [9:0] q,
                             input bit typed, input entry_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        row      <= r;
        col      <= c;
        data     <= d;
        index_p  <= p;
        index_q  <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op == OP_WRITE)
        begin
            matrix_copy[{r, c}]  = d;
            entry_loaded[{r, c}] = 1'b1;
        end
        else
            pending_entries.push_back(typed ? want : kernel_entry(p, q));
        burst_left--;
        @(negedge clk);
    endtask

    // write any entry the query would read that has never been written
    task automatic load_missing(input logic [9:0] p, input logic [9:0] q);
        bit          bad;
        int unsigned addr [4];
        int          cnt;
        entry_t      none;
        none.value = '0;
        none.oor   = 1'b0;
        split_query(p, q, bad, addr, cnt);
        for (int k = 0; k < cnt; k++)
        begin
            if (!entry_loaded[addr[k]])
                send_item(OP_WRITE, 6'(addr[k] / MAX_DIM), 6'(addr[k] % MAX_DIM), pick_data(),
                          10'($urandom()), 10'($urandom()), 1'b0, none);
        end
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_entries.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic apply_settings(input logic m, input logic [CFG_W-1:0] dim,
                                  input logic [CFG_W-1:0] n1, input logic [CFG_W-1:0] n2);
        logic [CFG_W-1:0] vals [4];
        logic [1:0]       regs [4];
        regs = '{REG_MODE, REG_DIRECT_DIM, REG_FIRST_GRP, REG_SECOND_GRP};
        vals = '{{6'($urandom()), m}, dim, n1, n2};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (regs[k])
                REG_MODE:       mode_reg = vals[k][0];
                REG_DIRECT_DIM: dim_reg  = vals[k];
                REG_FIRST_GRP:  n1_reg   = vals[k];
                REG_SECOND_GRP: n2_reg   = vals[k];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_step(input step_t s);
        entry_t want;
        if (s.kind == STEP_SETTINGS)
        begin
            quiesce();
            apply_settings(s.mode, s.dim, s.n1, s.n2);
        end
        else
        begin
            if (s.op == OP_QUERY)
                load_missing(s.p, s.q);
            want.value = s.value;
            want.oor   = s.oor;
            send_item(s.op, s.row, s.col, s.data, s.p, s.q, s.typed, want);
        end
    endtask

    always @(negedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 256 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_cycle[2];
        endcase
    end

    always @(posedge clk)
    begin : watch_results
        entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_entries.size() == 0)
                report_mismatch($sformatf("result %0d with none pending", entry_value));
            else
            begin
                want = pending_entries.pop_front();
                if (entry_value !== want.value)
                    report_mismatch($sformatf("entry_value %0d, predicted %0d",
                                              entry_value, want.value));
                if (out_of_range !== want.oor)
                    report_mismatch($sformatf("out_of_range %0b, predicted %0b",
                                              out_of_range, want.oor));
            end
        end
    end

    initial
    begin
        logic             m;
        logic [CFG_W-1:0] dim;
        logic [CFG_W-1:0] n1;
        logic [CFG_W-1:0] n2;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        opcode    = OP_WRITE;
        row       = '0;
        col       = '0;
        data      = '0;
        index_p   = '0;
        index_q   = '0;
        mode_reg  = MODE_DIRECT;
        dim_reg   = 64;
        n1_reg    = 32;
        n2_reg    = 32;

        directed.push_back(put_entry(0, 0, 32'h7FFF_FFFF));
        directed.push_back(put_entry(63, 63, 32'h8000_0000));
        directed.push_back(put_entry(32, 32, 32'h7FFF_FFFF));
        directed.push_back(put_entry(0, 32, 32'h8000_0000));
        directed.push_back(put_entry(32, 0, 32'h8000_0000));
        directed.push_back(ask_known(0, 0, 34'sd2147483647, 1'b0));
        directed.push_back(ask_known(63, 63, -34'sd2147483648, 1'b0));
        directed.push_back(ask_known(64, 0, '0, 1'b1));
        directed.push_back(ask_known(0, 1023, '0, 1'b1));
        directed.push_back(ask_known(1023, 1023, '0, 1'b1));
        directed.push_back(settings(MODE_DIRECT, 1, 32, 32));
        directed.push_back(ask_known(0, 0, 34'sd2147483647, 1'b0));
        directed.push_back(ask_known(1, 0, '0, 1'b1));
        directed.push_back(settings(MODE_DIRECT, 127, 32, 32));
        directed.push_back(ask_known(64, 63, '0, 1'b1));
        directed.push_back(settings(MODE_DIRECT, 0, 32, 32));
        directed.push_back(ask_known(0, 0, '0, 1'b1));
        directed.push_back(settings(MODE_PAIR, 64, 32, 32));
        directed.push_back(ask_known(0, 0, 34'sd8589934590, 1'b0));
        directed.push_back(ask(1023, 1023));
        directed.push_back(settings(MODE_PAIR, 64, 0, 64));
        directed.push_back(ask_known(5, 5, '0, 1'b1));
        directed.push_back(settings(MODE_PAIR, 64, 64, 1));
        directed.push_back(ask_known(0, 0, '0, 1'b1));
        directed.push_back(settings(MODE_PAIR, 64, 1, 0));
        directed.push_back(ask_known(3, 3, '0, 1'b1));
        directed.push_back(settings(MODE_PAIR, 64, 127, 127));
        directed.push_back(ask_known(0, 0, '0, 1'b1));
        directed.push_back(settings(MODE_PAIR, 64, 1, 63));
        directed.push_back(ask(62, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k]) run_step(directed[k]);

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    m = MODE_PAIR;   dim = CFG_W'(64); n1 = CFG_W'(1);  n2 = CFG_W'(1);
                end
                1:
                begin
                    m = MODE_PAIR;   dim = CFG_W'(64); n1 = CFG_W'(63); n2 = CFG_W'(1);
                end
                2:
                begin
                    m = MODE_PAIR;   dim = CFG_W'(64); n1 = CFG_W'(1);  n2 = CFG_W'(64);
                end
                3:
                begin
                    m = MODE_DIRECT; dim = CFG_W'(64); n1 = CFG_W'(32); n2 = CFG_W'(32);
                end
                default:
                begin
                    m   = 1'($urandom_range(0, 1));
                    dim = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 127))
                                                      : CFG_W'($urandom_range(1, 64));
                    n1  = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 127))
                                                      : CFG_W'($urandom_range(1, 63));
                    n2  = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 127))
                                                      : CFG_W'($urandom_range(1, 64));
                end
            endcase
            run_step(settings(m, dim, n1, n2));
            for (int k = 0; k < 20; k++)
            begin
                run_step(random_step());
                if ($urandom_range(0, 99) == 0)
                    quiesce();
            end
        end

        quiesce();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/pksg_pkg.sv
rtl/pksg_divider.sv
rtl/pksg_matrix_ram.sv
rtl/pair_kernel_submatrix_gather_core.sv
sim/testbench.sv
